### src/icph_pkg.sv
// Shared types, constants and helpers for the Internet checksum unit.
`default_nettype none

package icph_pkg;

  localparam int unsigned MAX_BYTES = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned PSUM_W    = 11;
  localparam logic [15:0] NO_LIMIT  = 16'hffff;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_ADDR    = 2'd1,
    ACT_PAYLOAD = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_ADDR    = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  protocol;
    logic [15:0] payload_length;
    logic [15:0] byte_limit;
    logic        with_pseudo;
    logic [31:0] address_word;
    logic [31:0] payload_data;
    logic [2:0]  payload_count;
    logic        payload_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic [15:0] bytes_summed;
  } out_item_t;

  // classified item as it sits in the queue
  typedef struct packed {
    kind_e                             kind;
    logic [15:0]                       value;
    logic [15:0]                       limit;
    logic [CNT_W-1:0]                  count;
    logic [MAX_BYTES:0][PSUM_W-1:0]    even_sum;
    logic [MAX_BYTES:0][PSUM_W-1:0]    odd_sum;
    logic                              last;
  } q_entry_t;

  // end-around carry fold of a 17-bit sum into 16 bits
  function automatic logic [15:0] oc_fold17(input logic [16:0] x);
    logic [16:0] y;
    y = 17'(x[15:0]) + 17'(x[16]);
    return y[15:0];
  endfunction

endpackage

`default_nettype wire

### src/icph_front.sv
// Front end: classifies items and prepares per-item byte sums.
`default_nettype none

module icph_front
  import icph_pkg::*;
#(
  parameter int unsigned BytesPerItem = 4
) (
  input  in_item_t item_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  localparam logic [CNT_W-1:0] BpiCnt = CNT_W'(BytesPerItem);

  logic [63:0]      data64;
  logic [CNT_W-1:0] cnt;
  logic [16:0]      pseudo_sum;
  logic [16:0]      addr_sum;

  assign data64     = {32'd0, item_i.payload_data};
  assign cnt        = ({1'b0, item_i.payload_count} > BpiCnt) ? BpiCnt
                                                              : {1'b0, item_i.payload_count};
  assign pseudo_sum = 17'(item_i.payload_length) + 17'(item_i.protocol);
  assign addr_sum   = 17'(item_i.address_word[31:16]) + 17'(item_i.address_word[15:0]);

  always_comb begin
    logic [7:0] byte_v;
    int         pos;
    entry_o          = '0;
    entry_o.limit    = item_i.byte_limit;
    entry_o.count    = cnt;
    entry_o.last     = item_i.payload_last;
    push_o           = 1'b1;
    entry_o.kind     = KIND_PAYLOAD;
    for (int i = 0; i < MAX_BYTES; i++) begin
      byte_v = '0;
      if (i < BytesPerItem) begin
        pos    = 8 * (BytesPerItem - 1 - i);
        byte_v = 8'(data64 >> pos);
      end
      if ((i % 2) == 0) begin
        entry_o.even_sum[i+1] = entry_o.even_sum[i] + PSUM_W'(byte_v);
        entry_o.odd_sum[i+1]  = entry_o.odd_sum[i];
      end else begin
        entry_o.even_sum[i+1] = entry_o.even_sum[i];
        entry_o.odd_sum[i+1]  = entry_o.odd_sum[i] + PSUM_W'(byte_v);
      end
    end
    case (item_i.action)
      ACT_START: begin
        entry_o.kind  = KIND_START;
        entry_o.value = item_i.with_pseudo ? oc_fold17(pseudo_sum) : 16'd0;
      end
      ACT_ADDR: begin
        entry_o.kind  = KIND_ADDR;
        entry_o.value = oc_fold17(addr_sum);
      end
      ACT_PAYLOAD: begin
        entry_o.kind = KIND_PAYLOAD;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/icph_fifo.sv
// Two-entry queue between front end and back end.
`default_nettype none

module icph_fifo
  import icph_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t wdata_i,
  output logic     full_o,
  output logic     empty_o,
  input  logic     pop_i,
  output q_entry_t rdata_o
);

  q_entry_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### src/icph_back.sv
// Back end: running ones'-complement sum, byte accounting and result register.
`default_nettype none

module icph_back
  import icph_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  q_entry_t  entry_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [15:0]      sum_q, sum_d;
  logic             odd_q, odd_d;
  logic [15:0]      left_q, left_d;
  logic [15:0]      taken_q, taken_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [CNT_W-1:0] n_take;
  logic [PSUM_W-1:0] e_sel, o_sel;
  logic [19:0]      addend;
  logic [20:0]      acc;
  logic [16:0]      fold1;
  logic [15:0]      sum_new;
  logic [16:0]      taken_inc;
  logic [15:0]      taken_new;

  assign pop_o       = !empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    if (left_q == NO_LIMIT || 16'(entry_i.count) <= left_q) begin
      n_take = entry_i.count;
    end else begin
      n_take = left_q[CNT_W-1:0];
    end
    e_sel = entry_i.even_sum[n_take];
    o_sel = entry_i.odd_sum[n_take];
    if (entry_i.kind == KIND_PAYLOAD) begin
      addend = odd_q ? (20'(o_sel) << 8) + 20'(e_sel) : (20'(e_sel) << 8) + 20'(o_sel);
    end else begin
      addend = 20'(entry_i.value);
    end
    acc       = 21'(sum_q) + 21'(addend);
    fold1     = 17'(acc[15:0]) + 17'(acc[20:16]);
    sum_new   = oc_fold17(fold1);
    taken_inc = 17'(taken_q) + 17'(n_take);
    taken_new = taken_inc[16] ? 16'hffff : taken_inc[15:0];
  end

  always_comb begin
    sum_d       = sum_q;
    odd_d       = odd_q;
    left_d      = left_q;
    taken_d     = taken_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      case (entry_i.kind)
        KIND_START: begin
          sum_d   = entry_i.value;
          odd_d   = 1'b0;
          taken_d = '0;
          left_d  = entry_i.limit;
        end
        KIND_ADDR: begin
          sum_d = sum_new;
        end
        KIND_PAYLOAD: begin
          sum_d   = sum_new;
          odd_d   = odd_q ^ n_take[0];
          taken_d = taken_new;
          if (left_q != NO_LIMIT) begin
            left_d = left_q - 16'(n_take);
          end
          if (entry_i.last) begin
            out_valid_d        = 1'b1;
            out_d.checksum     = ~sum_new;
            out_d.bytes_summed = taken_new;
            sum_d   = '0;
            odd_d   = 1'b0;
            taken_d = '0;
            left_d  = '0;
          end
        end
        default: begin
          sum_d = sum_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      odd_q       <= 1'b0;
      left_q      <= '0;
      taken_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      odd_q       <= odd_d;
      left_q      <= left_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

### src/internet_checksum_pseudo_header_unit.sv
// Internet checksum unit with optional pseudo header: front end, queue, back end.
// A final payload item's result is written to the output register when the back end pops it.
// Throughput: one item per cycle while the output is not stalled, bounded by the sum update in the back end.
// The two-entry queue absorbs output stalls; input stalls only when it is full.
// Reset (asynchronous, active low) clears the sum, parity, byte counters and queue.
`default_nettype none

module internet_checksum_pseudo_header_unit
  import icph_pkg::*;
#(
  parameter int unsigned BytesPerItem = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  q_entry_t front_entry, q_entry;
  logic     front_push, q_full, q_empty, q_pop;

  icph_front #(
    .BytesPerItem(BytesPerItem)
  ) u_front (
    .item_i (in_item_i),
    .push_o (front_push),
    .entry_o(front_entry)
  );

  icph_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i && front_push),
    .wdata_i(front_entry),
    .full_o (q_full),
    .empty_o(q_empty),
    .pop_i  (q_pop),
    .rdata_o(q_entry)
  );

  icph_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .entry_i    (q_entry),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  assign in_stall_o = q_full;

endmodule

`default_nettype wire

### tb/sv/internet_checksum_pseudo_header_unit_tb.sv
// Self-checking testbench for the Internet checksum unit: directed table, random packets.
`timescale 1ns / 100ps

module internet_checksum_pseudo_header_unit_tb;
  import icph_pkg::*;

  localparam int          BYTES_PER_ITEM = 4;
  localparam logic [1:0]  ACT_NONE       = 2'd3;
  localparam int          DIR_ROWS       = 25;
  localparam int          RANDOM_ITEMS   = 1150;
  localparam int          IDLE_PCT       = 27;
  localparam int          CALM_FROM      = 600;
  localparam int          CALM_TO        = 800;
  localparam int          DRAIN_EVERY    = 400;
  localparam int          TAIL_CYCLES    = 6;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
    logic      drain;
  } stim_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic      calm      = 1'b0;
  logic      stim_done = 1'b0;

  stim_t     stim [$];
  out_item_t expected_sums [$];
  int        stim_idx     = 0;
  int        items_in     = 0;
  int        sums_checked = 0;
  int        fail_count   = 0;
  int        useful_items = 0;
  int        quiet_cycles = 0;

  // predictor state
  logic [15:0] sum_acc   = '0;
  logic        odd_byte  = 1'b0;
  logic [15:0] left_cnt  = '0;
  logic [15:0] taken_cnt = '0;

  out_item_t pred_res;
  out_item_t want;
  bit        has_res;

  // byte limit 0 swallows the payload
  stim_t directed_tbl [DIR_ROWS] = '{
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'hffffffff, 3'd4, 1'b1},
      1'b1, '{16'hffff, 16'd0}, 1'b0},
    '{'{ACT_NONE, 8'hff, 16'hffff, 16'hffff, 1'b1, 32'hffffffff, 32'hffffffff, 3'd7, 1'b1},
      1'b0, '0, 1'b0},
    '{'{ACT_START, 8'h00, 16'h0000, 16'hffff, 1'b0, 32'h0, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h00000000, 3'd4, 1'b1},
      1'b1, '{16'hffff, 16'd4}, 1'b0},
    '{'{ACT_START, 8'h06, 16'h0014, 16'hffff, 1'b1, 32'h0, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'hc0a80001, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'hc0a800c7, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h12345678, 3'd4, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h9abcdef0, 3'd3, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'ha5a5a5a5, 3'd7, 1'b1},
      1'b0, '0, 1'b0},
    '{'{ACT_START, 8'hff, 16'hffff, 16'h0000, 1'b1, 32'h0, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'hffffffff, 3'd4, 1'b1},
      1'b0, '0, 1'b0},
    '{'{ACT_START, 8'h11, 16'hffff, 16'h0003, 1'b1, 32'h0, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h0102ffff, 3'd2, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'hffffffff, 3'd4, 1'b1},
      1'b0, '0, 1'b0},
    '{'{ACT_START, 8'h11, 16'h0028, 16'hffff, 1'b1, 32'h0, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'hffffffff, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h00000000, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'hfe800000, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h00000001, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'hffffffff, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h80000000, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0000ffff, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_ADDR, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'hffff0000, 32'h0, 3'd0, 1'b0},
      1'b0, '0, 1'b0},
    '{'{ACT_PAYLOAD, 8'h00, 16'h0000, 16'h0000, 1'b0, 32'h0, 32'h00000000, 3'd0, 1'b1},
      1'b0, '0, 1'b0}
  };

  internet_checksum_pseudo_header_unit #(
    .BytesPerItem(BYTES_PER_ITEM)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic bit predict_checksum(input in_item_t it, output out_item_t res);
    int          n;
    logic [7:0]  b;
    res = '0;
    case (it.action)
      ACT_START: begin
        sum_acc   = '0;
        odd_byte  = 1'b0;
        taken_cnt = '0;
        left_cnt  = it.byte_limit;
        if (it.with_pseudo) begin
          sum_acc = ones_add(sum_acc, {8'h00, it.protocol});
          sum_acc = ones_add(sum_acc, it.payload_length);
        end
        return 1'b0;
      end
      ACT_ADDR: begin
        sum_acc = ones_add(sum_acc, it.address_word[31:16]);
        sum_acc = ones_add(sum_acc, it.address_word[15:0]);
        return 1'b0;
      end
      ACT_PAYLOAD: begin
        n = (int'(it.payload_count) > BYTES_PER_ITEM) ? BYTES_PER_ITEM : int'(it.payload_count);
        for (int i = 0; i < n && left_cnt != 16'd0; i++) begin
          b = it.payload_data[8*(BYTES_PER_ITEM-1-i) +: 8];
          sum_acc  = odd_byte ? ones_add(sum_acc, {8'h00, b}) : ones_add(sum_acc, {b, 8'h00});
          odd_byte = ~odd_byte;
          if (taken_cnt != NO_LIMIT) taken_cnt = taken_cnt + 16'd1;
          if (left_cnt != NO_LIMIT) left_cnt = left_cnt - 16'd1;
        end
        if (!it.payload_last) return 1'b0;
        res.checksum     = ~sum_acc;
        res.bytes_summed = taken_cnt;
        sum_acc   = '0;
        odd_byte  = 1'b0;
        left_cnt  = '0;
        taken_cnt = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic push_item(input in_item_t it);
    stim_t s;
    s = '{item: it, typed: 1'b0, res: '0, drain: 1'b0};
    stim.push_back(s);
    if (it.action != ACT_NONE) useful_items++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stimulus build: directed table, then packets with random content and some noise
  initial begin
    in_item_t it;
    int       n_addr;
    int       n_pay;
    int       roll;
    bit       broken;
    for (int r = 0; r < DIR_ROWS; r++) stim.push_back(directed_tbl[r]);
    while (useful_items < RANDOM_ITEMS + DIR_ROWS) begin
      if ($urandom_range(0, 99) < 88) begin
        it = rand_item();
        it.action = ACT_START;
        case ($urandom_range(0, 3))
          0:       it.byte_limit = NO_LIMIT;
          1:       it.byte_limit = 16'($urandom_range(0, 12));
          2:       it.byte_limit = 16'($urandom);
          default: it.byte_limit = 16'($urandom_range(13, 40));
        endcase
        push_item(it);
        case ($urandom_range(0, 3))
          0:       n_addr = 0;
          1:       n_addr = 2;
          2:       n_addr = 8;
          default: n_addr = $urandom_range(0, 9);
        endcase
        for (int k = 0; k < n_addr; k++) begin
          it = rand_item();
          it.action = ACT_ADDR;
          push_item(it);
        end
        n_pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        broken = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < n_pay; k++) begin
          it = rand_item();
          it.action = ACT_PAYLOAD;
          roll = $urandom_range(0, 99);
          if (roll < 80)      it.payload_count = 3'($urandom_range(1, 4));
          else if (roll < 90) it.payload_count = 3'd0;
          else                it.payload_count = 3'($urandom_range(5, 7));
          it.payload_last = (k == n_pay - 1) && !broken;
          push_item(it);
          if ($urandom_range(0, 29) == 0) begin
            it = rand_item();
            it.action = ($urandom_range(0, 1) == 0) ? ACT_ADDR : ACT_NONE;
            push_item(it);
          end
        end
      end else begin
        push_item(rand_item());
      end
    end
    for (int k = DIR_ROWS; k < stim.size(); k += DRAIN_EVERY) stim[k].drain = 1'b1;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sender and predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        has_res = predict_checksum(stim[stim_idx].item, pred_res);
        if (stim[stim_idx].typed) pred_res = stim[stim_idx].res;
        if (has_res || stim[stim_idx].typed) expected_sums.push_back(pred_res);
        items_in++;
        stim_idx++;
      end
      calm <= (stim_idx >= CALM_FROM) && (stim_idx < CALM_TO);
      if (!in_valid || !in_stall) begin
        if (stim_idx >= stim.size()) begin
          in_valid  <= 1'b0;
          stim_done <= 1'b1;
        end else if (stim[stim_idx].drain && expected_sums.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_item  <= stim[stim_idx].item;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result checksum %h bytes %0d",
                   $time, out_item.checksum, out_item.bytes_summed);
        end else begin
          want = expected_sums.pop_front();
          if (out_item.checksum !== want.checksum) begin
            fail_count++;
            $display("%0t: checksum expected %h got %h", $time, want.checksum, out_item.checksum);
          end
          if (out_item.bytes_summed !== want.bytes_summed) begin
            fail_count++;
            $display("%0t: bytes_summed expected %0d got %0d",
                     $time, want.bytes_summed, out_item.bytes_summed);
          end
        end
        sums_checked++;
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_sums.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (!stim_done || expected_sums.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_sums.size() != 0) fail_count++;
    $display("Sent %0d items (%0d directed rows), checked %0d checksum results.",
             items_in, DIR_ROWS, sums_checked);
    $display("Packets mixed IPv4, IPv6 and plain sums, byte limits, noise and drain pauses.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
